FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define CWSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define CWSP_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/cwsp_pkg.sv
// shared widths and constants of the way sequence predictor
package cwsp_pkg;

  localparam int SET_W = 6;
  localparam int WAY_W = 3;
  localparam int CONF_W = 2;
  localparam logic [CONF_W-1:0] CONF_MAX = 2'd3;

  localparam int DEF_SETS = 64;
  localparam int DEF_WAYS = 8;

endpackage

FILE: rtl/cwsp_in_if.sv
// access channel: set index, hit flag, hit way and writeback flag
interface cwsp_in_if import cwsp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SET_W-1:0] set_index;
  logic             line_hit;
  logic [WAY_W-1:0] hit_way;
  logic             is_writeback;

  modport source (output valid, set_index, line_hit, hit_way, is_writeback, input ready);
  modport sink (input valid, set_index, line_hit, hit_way, is_writeback, output ready);
endinterface

FILE: rtl/cwsp_out_if.sv
// prefetch channel: set and predicted way
interface cwsp_out_if import cwsp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SET_W-1:0] prefetch_set;
  logic [WAY_W-1:0] prefetch_way;

  modport source (output valid, prefetch_set, prefetch_way, input ready);
  modport sink (input valid, prefetch_set, prefetch_way, output ready);
endinterface

FILE: rtl/cwsp_ram.sv
// generic single write port, single read port ram with registered read
module cwsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cache_way_sequence_predictor_unit.sv
// top level of the cache way sequence predictor
// a qualified access goes idle (last-way and successor read), prev (previous way's
//   successor read), update (write-back, prefetch load; held if an older one stalls)
//   before the next is accepted; writebacks, misses, out of range accesses stay idle
// reset: synchronous; a clearing sweep over all SETS*WAYS slots (512 by default)
//   zeroes both rams while in_chan.ready stays low
module cache_way_sequence_predictor_unit import cwsp_pkg::*; #(
  parameter int SETS = DEF_SETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic        clk,
  input  logic        rst_n,
  cwsp_in_if.sink     in_chan,
  cwsp_out_if.source  out_chan
);

`include "assert_macros.svh"

  localparam int SIDX_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS = SETS * WAYS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W = WIDX_W + CONF_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_PREV = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SET_W-1:0]  set_r;
  logic [WIDX_W-1:0] cur_r;
  logic [WIDX_W-1:0] p_r;
  logic [ENT_W-1:0]  cur_ent_r;
  logic [SLOT_W-1:0] prev_slot_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SET_W-1:0]  out_set_r;
  logic [WAY_W-1:0]  out_way_r;

  logic              accept;
  logic              qualify;
  logic [WIDX_W-1:0] in_way;
  logic [SIDX_W-1:0] in_set;
  logic [SIDX_W-1:0] set_idx_r;
  logic [SLOT_W-1:0] prev_slot;
  logic              clr_done;

  logic              last_we;
  logic [SIDX_W-1:0] last_waddr;
  logic [WIDX_W-1:0] last_wdata;
  logic              last_re;
  logic [WIDX_W-1:0] last_rdata;

  logic              succ_we;
  logic [SLOT_W-1:0] succ_waddr;
  logic [ENT_W-1:0]  succ_wdata;
  logic              succ_re;
  logic [SLOT_W-1:0] succ_raddr;
  logic [ENT_W-1:0]  succ_rdata;

  logic [WIDX_W-1:0] pw;
  logic [CONF_W-1:0] pc;
  logic [ENT_W-1:0]  trained;
  logic [ENT_W-1:0]  pred_ent;
  logic              emit;
  logic              advance;
  logic              load;

  assign in_way = WIDX_W'(in_chan.hit_way);
  assign in_set = SIDX_W'(in_chan.set_index);
  assign set_idx_r = SIDX_W'(set_r);
  assign accept = in_chan.valid && in_chan.ready;
  assign qualify = in_chan.line_hit && !in_chan.is_writeback &&
                   (32'(in_chan.set_index) < SETS) && (32'(in_chan.hit_way) < WAYS);
  assign in_chan.ready = (st_r == ST_IDLE);
  assign clr_done = (clr_cnt_r == SLOT_W'(SLOTS - 1));

  assign prev_slot = SLOT_W'(SLOT_W'(set_idx_r) * SLOT_W'(WAYS)) + SLOT_W'(last_rdata);

  // training of the previous way's successor entry
  assign pw = succ_rdata[ENT_W-1:CONF_W];
  assign pc = succ_rdata[CONF_W-1:0];
  always_comb begin
    if (pw == cur_r) begin
      trained = {pw, (pc == CONF_MAX) ? pc : CONF_W'(pc + 1'b1)};
    end else begin
      trained = {cur_r, {CONF_W{1'b0}}};
    end
  end

  // prediction sees the freshly trained entry when previous and current way match
  assign pred_ent = (p_r == cur_r) ? trained : cur_ent_r;
  assign emit = (pred_ent[CONF_W-1:0] == CONF_MAX);
  assign advance = !(emit && out_valid_r && !out_chan.ready);
  assign load = (st_r == ST_UPD) && advance && emit;

  always_comb begin
    last_we = 1'b0;
    last_waddr = set_idx_r;
    last_wdata = cur_r;
    succ_we = 1'b0;
    succ_waddr = prev_slot_r;
    succ_wdata = trained;
    case (st_r)
      ST_CLR: begin
        last_we = (32'(clr_cnt_r) < SETS);
        last_waddr = SIDX_W'(clr_cnt_r);
        last_wdata = '0;
        succ_we = 1'b1;
        succ_waddr = clr_cnt_r;
        succ_wdata = '0;
      end
      ST_UPD: begin
        last_we = advance;
        succ_we = advance;
      end
      default: begin
      end
    endcase
  end

  assign last_re = accept && qualify;
  assign succ_re = (accept && qualify) || (st_r == ST_PREV);
  assign succ_raddr = (st_r == ST_PREV) ? prev_slot :
                      SLOT_W'(SLOT_W'(SLOT_W'(in_set) * SLOT_W'(WAYS)) + SLOT_W'(in_way));

  always_comb begin
    st_nxt = st_r;
    clr_cnt_nxt = clr_cnt_r;
    case (st_r)
      ST_CLR: begin
        clr_cnt_nxt = SLOT_W'(clr_cnt_r + 1'b1);
        if (clr_done) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && qualify) begin
          st_nxt = ST_PREV;
        end
      end
      ST_PREV: begin
        st_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (advance) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= in_chan.set_index;
      cur_r <= in_way;
    end
    if (st_r == ST_PREV) begin
      p_r <= last_rdata;
      cur_ent_r <= succ_rdata;
      prev_slot_r <= prev_slot;
    end
    if (load) begin
      out_set_r <= set_r;
      out_way_r <= WAY_W'(pred_ent[ENT_W-1:CONF_W]);
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.prefetch_set = out_set_r;
  assign out_chan.prefetch_way = out_way_r;

  cwsp_ram #(
    .WIDTH (WIDX_W),
    .DEPTH (SETS)
  ) u_last_ram (
    .clk     (clk),
    .we      (last_we),
    .waddr   (last_waddr),
    .wdata   (last_wdata),
    .re      (last_re),
    .raddr   (in_set),
    .rdata_r (last_rdata)
  );

  cwsp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_succ_ram (
    .clk     (clk),
    .we      (succ_we),
    .waddr   (succ_waddr),
    .wdata   (succ_wdata),
    .re      (succ_re),
    .raddr   (succ_raddr),
    .rdata_r (succ_rdata)
  );

  `CWSP_ASSERT(a_accept_to_prev, accept && qualify |=> st_r == ST_PREV, "qualified access did not start a lookup")
  `CWSP_ASSERT(a_prev_way_range, st_r == ST_UPD |-> 32'(p_r) < WAYS, "last way read out of range")
  `CWSP_ASSERT(a_clear_ends, st_r == ST_CLR && clr_done |=> st_r == ST_IDLE, "clearing sweep did not end")
  `CWSP_ASSERT(a_load_shows, load |=> out_valid_r && out_set_r == $past(set_r), "result not presented")

endmodule

FILE: sim/cache_way_sequence_predictor_unit_tb.sv
// testbench for the cache way sequence predictor: directed and random accesses checked against a predictor
module cache_way_sequence_predictor_unit_tb import cwsp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_COUNT = DEF_SETS;
  localparam int WAY_COUNT = DEF_WAYS;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_TRAINED = 1400;

  typedef struct packed {
    logic [SET_W-1:0] pf_set;
    logic [WAY_W-1:0] pf_way;
  } prefetch_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cwsp_in_if in_chan ();
  cwsp_out_if out_chan ();

  cache_way_sequence_predictor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predictor state
  logic [WAY_W-1:0]  recent_way [SET_COUNT];
  logic [WAY_W-1:0]  succ_way   [SET_COUNT][WAY_COUNT];
  logic [CONF_W-1:0] succ_conf  [SET_COUNT][WAY_COUNT];

  prefetch_t prefetch_q[$];
  bit no_idle = 1'b0;
  int access_count = 0;
  int trained_count = 0;
  int prefetch_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // trains the set's sequence table and tells whether a prefetch follows
  function automatic bit train_and_predict(input logic [SET_W-1:0] s, input logic h,
                                           input logic [WAY_W-1:0] w, input logic wb,
                                           output prefetch_t pf);
    logic [WAY_W-1:0] p;
    pf = '0;
    if (wb || !h) return 1'b0;
    if (int'(s) >= SET_COUNT || int'(w) >= WAY_COUNT) return 1'b0;
    p = recent_way[s];
    if (succ_way[s][p] == w) begin
      if (succ_conf[s][p] != CONF_MAX) succ_conf[s][p] = succ_conf[s][p] + 1'b1;
    end else begin
      succ_way[s][p] = w;
      succ_conf[s][p] = '0;
    end
    recent_way[s] = w;
    if (succ_conf[s][w] == CONF_MAX) begin
      pf.pf_set = s;
      pf.pf_way = succ_way[s][w];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_access(input logic [SET_W-1:0] s, input logic h,
                             input logic [WAY_W-1:0] w, input logic wb);
    int gap;
    prefetch_t pf;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.set_index <= s;
    in_chan.line_hit <= h;
    in_chan.hit_way <= w;
    in_chan.is_writeback <= wb;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    access_count++;
    if (h && !wb) trained_count++;
    if (train_and_predict(s, h, w, wb, pf)) prefetch_q.push_back(pf);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (prefetch_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input prefetch_t exp_pf,
                                 input prefetch_t act_pf);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): expected set %0d way %0d, got set %0d way %0d", what,
               exp_pf.pf_set, exp_pf.pf_way, act_pf.pf_set, act_pf.pf_way);
  endtask

  // result checker
  always @(posedge clk) begin
    prefetch_t act_pf;
    prefetch_t exp_pf;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      act_pf.pf_set = out_chan.prefetch_set;
      act_pf.pf_way = out_chan.prefetch_way;
      prefetch_count++;
      if (prefetch_q.size() == 0) begin
        report_mismatch("unexpected prefetch", '0, act_pf);
      end else begin
        exp_pf = prefetch_q.pop_front();
        if (act_pf.pf_set !== exp_pf.pf_set) report_mismatch("prefetch_set", exp_pf, act_pf);
        if (act_pf.pf_way !== exp_pf.pf_way) report_mismatch("prefetch_way", exp_pf, act_pf);
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    int g;
    if (no_idle) begin
      out_chan.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = pick_gap();
      out_chan.ready <= (g == 0);
      if (g > 0) stall_left <= g - 1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("cache_way_sequence_predictor_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed_cases();
    int k;
    // repeated hit on the reset entry reaches full confidence
    repeat (4) send_access(6'd0, 1'b1, 3'd0, 1'b0);
    send_access(6'd0, 1'b1, 3'd0, 1'b1);
    send_access(6'd0, 1'b0, 3'd0, 1'b0);
    send_access(6'd63, 1'b0, 3'd7, 1'b1);
    send_access(6'd63, 1'b1, 3'd7, 1'b1);
    // alternating extreme ways in the top set
    for (k = 0; k < 10; k++) send_access(6'd63, 1'b1, (k % 2 == 0) ? 3'd7 : 3'd0, 1'b0);
    // writebacks and misses between trainings leave the sequence intact
    for (k = 0; k < 4; k++) begin
      send_access(6'd42, 1'b1, 3'd5, 1'b0);
      if (k % 2 == 0) send_access(6'd42, 1'b1, 3'd2, 1'b1);
      else send_access(6'd42, 1'b0, 3'd2, 1'b0);
    end
  endtask

  task automatic test_back_to_back();
    int k;
    no_idle = 1'b1;
    for (k = 0; k < 24; k++) send_access(6'd5, 1'b1, (k % 2 == 0) ? 3'd1 : 3'd2, 1'b0);
    repeat (6) send_access(6'd5, 1'b1, 3'd6, 1'b0);
    for (k = 0; k < 30; k++) send_access((k % 2 == 0) ? 6'd10 : 6'd11, 1'b1, 3'(k % 3), 1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    int k;
    for (k = 0; k < 20; k++) send_access(6'd33, 1'b1, 3'(3 + k % 3), 1'b0);
    wait_drained();
    for (k = 0; k < 20; k++) send_access(6'd33, 1'b1, 3'(3 + k % 3), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_sequences();
    logic [SET_W-1:0] hot_sets [4];
    logic [WAY_W-1:0] pattern [4];
    logic [SET_W-1:0] s;
    int target;
    int len;
    int reps;
    int r;
    int k;
    hot_sets = '{6'd0, 6'd21, 6'd42, 6'd63};
    target = trained_count + RANDOM_TRAINED;
    while (trained_count < target) begin
      no_idle = ($urandom_range(0, 19) == 0);
      s = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                      : hot_sets[$urandom_range(0, 3)];
      len = $urandom_range(1, 4);
      reps = $urandom_range(2, 6);
      for (k = 0; k < 4; k++) pattern[k] = 3'($urandom_range(0, 7));
      for (r = 0; r < reps; r++) begin
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0)
              send_access(6'($urandom_range(0, 63)), 1'($urandom), 3'($urandom_range(0, 7)), 1'b1);
            else
              send_access(6'($urandom_range(0, 63)), 1'b0, 3'($urandom_range(0, 7)), 1'($urandom));
          end
          if ($urandom_range(0, 7) == 0)
            send_access(6'($urandom_range(0, 63)), 1'b1, 3'($urandom_range(0, 7)), 1'b0);
          send_access(s, 1'b1, pattern[k], 1'b0);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int i;
    int j;
    for (i = 0; i < SET_COUNT; i++) begin
      recent_way[i] = '0;
      for (j = 0; j < WAY_COUNT; j++) begin
        succ_way[i][j] = '0;
        succ_conf[i][j] = '0;
      end
    end
    in_chan.valid = 1'b0;
    in_chan.set_index = '0;
    in_chan.line_hit = 1'b0;
    in_chan.hit_way = '0;
    in_chan.is_writeback = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_back_to_back();
    test_drain_pause();
    test_random_sequences();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d accesses (%0d trained, rest writebacks and misses)",
             access_count, trained_count);
    $display("checked %0d prefetches, %0d mismatches", prefetch_count, mismatch_count);
    if (mismatch_count == 0 && prefetch_q.size() == 0)
      $display("cache_way_sequence_predictor_unit regression: pass");
    else
      $display("cache_way_sequence_predictor_unit regression: fail");
    $finish;
  end

endmodule
